// ===== design/vsrt_pkg.sv =====
`default_nettype none
package vsrt_pkg;
	localparam int CordicSteps = 20;
	localparam int CordicStart = 652032874;
	localparam int InnerBits = 46;

	typedef enum logic [2:0] {
		REG_SCALE   = 3'd0,
		REG_ANGLE_X = 3'd1,
		REG_ANGLE_Y = 3'd2,
		REG_ANGLE_Z = 3'd3,
		REG_OFFSET_X = 3'd4,
		REG_OFFSET_Y = 3'd5,
		REG_OFFSET_Z = 3'd6,
		REG_SPARE   = 3'd7
	} reg_index_t;

	typedef logic signed [33:0] cordic_word_t;

	typedef struct packed {
		cordic_word_t x;
		cordic_word_t y;
		cordic_word_t r;
	} cordic_state_t;

	function automatic logic [31:0] atan_step(input int i);
		logic [31:0] v;
		case (i)
			0: v = 32'd536870912;
			1: v = 32'd316933406;
			2: v = 32'd167458907;
			3: v = 32'd85004756;
			4: v = 32'd42667331;
			5: v = 32'd21354465;
			6: v = 32'd10679838;
			7: v = 32'd5340245;
			8: v = 32'd2670163;
			9: v = 32'd1335087;
			10: v = 32'd667544;
			11: v = 32'd333772;
			12: v = 32'd166886;
			13: v = 32'd83443;
			14: v = 32'd41722;
			15: v = 32'd20861;
			16: v = 32'd10430;
			17: v = 32'd5215;
			18: v = 32'd2608;
			default: v = 32'd1304;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

// ===== design/vsrt_stream_if.sv =====
`default_nettype none
interface vsrt_stream_if #(parameter int W = 72);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/vertex_scale_rotate_translate.sv =====
`default_nettype none
// Vertex scale, rotate and translate pipeline.
// Channel in_ch carries {vertex_z, vertex_y, vertex_x}, each a signed
// fixed-point coordinate with 8 fraction bits; out_ch carries
// {clipped, moved_z, moved_y, moved_x}. A transaction completes when valid
// and ready are both high at a rising clock edge.
// One vertex is taken every cycle while in_ch.ready is high. The pipeline
// is made of one scale stage, two stages for each of
// the three rotations and one translate stage.
// The whole pipeline advances together; when the receiver stalls with a
// result held, in_ch.ready falls and every stage holds.
// Registers are written through cfg_we, cfg_index and cfg_data. The user
// must write them only while idle; the block does not enforce it. Sine and
// cosine come from a chain of 20 CORDIC cells per axis; after reset and
// every register write, in_ch.ready stays low while the chains settle.
// Reset empties the pipeline and loads unit scale, zero angles and offsets.
module vertex_scale_rotate_translate #(
	parameter int COORD_WIDTH = 24,
	parameter int ANGLE_WIDTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [47:0] cfg_data,
	vsrt_stream_if.sink in_ch,
	vsrt_stream_if.source out_ch
);
	localparam int CW = COORD_WIDTH;
	localparam int IB = vsrt_pkg::InnerBits;
	localparam int SW = (CW + 18 > IB + 2) ? CW + 18 : IB + 2;
	localparam int FW = ((CW > IB) ? CW : IB) + 2;
	localparam int Depth = 8;
	localparam int SettleCycles = vsrt_pkg::CordicSteps + 1;
	localparam logic signed [SW-1:0] Lim = SW'(64'sd17592186044415);
	localparam logic signed [FW-1:0] Hi = FW'((64'sd1 <<< (CW-1)) - 1);
	localparam logic signed [FW-1:0] Lo = -Hi - 1;

	logic [47:0] scale_q;
	logic [ANGLE_WIDTH-1:0] ang_x_q, ang_y_q, ang_z_q;
	logic signed [CW-1:0] off_x_q, off_y_q, off_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= 48'h0100_0100_0100;
			ang_x_q <= '0; ang_y_q <= '0; ang_z_q <= '0;
			off_x_q <= '0; off_y_q <= '0; off_z_q <= '0;
		end else if (cfg_we) begin
			unique case (vsrt_pkg::reg_index_t'(cfg_index))
				vsrt_pkg::REG_SCALE:    scale_q <= cfg_data;
				vsrt_pkg::REG_ANGLE_X:  ang_x_q <= cfg_data[ANGLE_WIDTH-1:0];
				vsrt_pkg::REG_ANGLE_Y:  ang_y_q <= cfg_data[ANGLE_WIDTH-1:0];
				vsrt_pkg::REG_ANGLE_Z:  ang_z_q <= cfg_data[ANGLE_WIDTH-1:0];
				vsrt_pkg::REG_OFFSET_X: off_x_q <= cfg_data[CW-1:0];
				vsrt_pkg::REG_OFFSET_Y: off_y_q <= cfg_data[CW-1:0];
				vsrt_pkg::REG_OFFSET_Z: off_z_q <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	logic [4:0] settle_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) settle_q <= 5'(SettleCycles);
		else if (cfg_we) settle_q <= 5'(SettleCycles);
		else if (settle_q != '0) settle_q <= settle_q - 5'd1;
	end

	logic signed [17:0] cx, sx, cy, sy, cz, sz;
	vsrt_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_sc_x (.clk(clk), .angle(ang_x_q),
		.cos_q(cx), .sin_q(sx));
	vsrt_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_sc_y (.clk(clk), .angle(ang_y_q),
		.cos_q(cy), .sin_q(sy));
	vsrt_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_sc_z (.clk(clk), .angle(ang_z_q),
		.cos_q(cz), .sin_q(sz));

	logic [Depth-1:0] vld_q;
	logic en;
	assign en = out_ch.ready || !vld_q[Depth-1];
	assign in_ch.ready = en && (settle_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[Depth-2:0], in_ch.valid && in_ch.ready};
	end

	logic signed [CW-1:0] vx, vy, vz;
	assign vx = in_ch.data[CW-1:0];
	assign vy = in_ch.data[2*CW-1:CW];
	assign vz = in_ch.data[3*CW-1:2*CW];

	function automatic logic signed [SW-1:0] scl(input logic signed [CW-1:0] v,
		input logic [15:0] f);
		logic signed [SW-1:0] p;
		p = (v * $signed({1'b0, f}) + SW'(128)) >>> 8;
		return p;
	endfunction

	function automatic logic signed [SW-1:0] lim(input logic signed [SW-1:0] v);
		return (v > Lim) ? Lim : ((v < -Lim) ? -Lim : v);
	endfunction

	logic signed [SW-1:0] tx, ty, tz, lx, ly, lz;
	logic signed [IB-1:0] x_s1, y_s1, z_s1;
	logic clip_s1;
	assign tx = scl(vx, scale_q[15:0]);
	assign ty = scl(vy, scale_q[31:16]);
	assign tz = scl(vz, scale_q[47:32]);
	assign lx = lim(tx);
	assign ly = lim(ty);
	assign lz = lim(tz);
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= lx[IB-1:0];
			y_s1 <= ly[IB-1:0];
			z_s1 <= lz[IB-1:0];
			clip_s1 <= (tx != lx) || (ty != ly) || (tz != lz);
		end
	end

	// Delay lines carry the untouched axis alongside each rotation.
	logic signed [IB-1:0] y_s3, z_s3, x_s2, x_s3, z_s5, x_s5, y_s4, y_s5;
	logic signed [IB-1:0] x_s7, y_s7, z_s6, z_s7;
	logic clip_s3, clip_s5, clip_s7;

	vsrt_rotate_cell u_rx (.clk(clk), .en(en), .a(y_s1), .b(z_s1), .c(cx), .s(sx),
		.clip_in(clip_s1), .a_s2(y_s3), .b_s2(z_s3), .clip_s2(clip_s3));
	always_ff @(posedge clk) if (en) begin x_s2 <= x_s1; x_s3 <= x_s2; end

	vsrt_rotate_cell u_ry (.clk(clk), .en(en), .a(z_s3), .b(x_s3), .c(cy), .s(sy),
		.clip_in(clip_s3), .a_s2(z_s5), .b_s2(x_s5), .clip_s2(clip_s5));
	always_ff @(posedge clk) if (en) begin y_s4 <= y_s3; y_s5 <= y_s4; end

	vsrt_rotate_cell u_rz (.clk(clk), .en(en), .a(x_s5), .b(y_s5), .c(cz), .s(sz),
		.clip_in(clip_s5), .a_s2(x_s7), .b_s2(y_s7), .clip_s2(clip_s7));
	always_ff @(posedge clk) if (en) begin z_s6 <= z_s5; z_s7 <= z_s6; end

	logic signed [FW-1:0] ox, oy, oz, fx, fy, fz;
	assign ox = FW'(x_s7) + FW'(off_x_q);
	assign oy = FW'(y_s7) + FW'(off_y_q);
	assign oz = FW'(z_s7) + FW'(off_z_q);
	assign fx = (ox > Hi) ? Hi : ((ox < Lo) ? Lo : ox);
	assign fy = (oy > Hi) ? Hi : ((oy < Lo) ? Lo : oy);
	assign fz = (oz > Hi) ? Hi : ((oz < Lo) ? Lo : oz);

	logic [3*CW:0] res_s8;
	always_ff @(posedge clk) begin
		if (en) begin
			res_s8 <= {clip_s7 || (ox != fx) || (oy != fy) || (oz != fz),
				fz[CW-1:0], fy[CW-1:0], fx[CW-1:0]};
		end
	end
	assign out_ch.valid = vld_q[Depth-1];
	assign out_ch.data = res_s8;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
		else $error("result changed while stalled");
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_ch.valid && settle_q == '0) |-> in_ch.ready)
		else $error("input blocked with empty output stage");
	a_pipe_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.ready && !vld_q[Depth-2]) |=> !out_ch.valid)
		else $error("output valid without a vertex in flight");
endmodule
`default_nettype wire

// ===== design/vsrt_cordic_cell.sv =====
`default_nettype none
// One CORDIC micro-rotation; the cells form a chain that settles the sine
// and cosine after every angle register write.
module vsrt_cordic_cell #(parameter int STEP = 0) (
	input  wire logic clk,
	input  wire vsrt_pkg::cordic_state_t prev,
	output vsrt_pkg::cordic_state_t next_q
);
	vsrt_pkg::cordic_word_t dx, dy, at;
	assign dx = prev.y >>> STEP;
	assign dy = prev.x >>> STEP;
	assign at = $signed({2'b00, vsrt_pkg::atan_step(STEP)});
	always_ff @(posedge clk) begin
		if (prev.r >= 0) begin
			next_q.x <= prev.x - dx;
			next_q.y <= prev.y + dy;
			next_q.r <= prev.r - at;
		end else begin
			next_q.x <= prev.x + dx;
			next_q.y <= prev.y - dy;
			next_q.r <= prev.r + at;
		end
	end
endmodule
`default_nettype wire

// ===== design/vsrt_sincos.sv =====
`default_nettype none
module vsrt_sincos #(parameter int ANGLE_WIDTH = 16) (
	input  wire logic clk,
	input  wire logic [ANGLE_WIDTH-1:0] angle,
	output logic signed [17:0] cos_q,
	output logic signed [17:0] sin_q
);
	localparam int N = vsrt_pkg::CordicSteps;
	vsrt_pkg::cordic_state_t chain [0:N];
	logic [31:0] a, d;
	logic [1:0] q;
	logic [1:0] q_pipe [0:N];
	logic signed [33:0] xr, yr;
	logic signed [17:0] xc, yc;
	assign a = {angle, {(32-ANGLE_WIDTH){1'b0}}};
	assign q = 2'((a + 32'h2000_0000) >> 30);
	assign d = a - {q, 30'd0};
	assign chain[0].x = 34'(vsrt_pkg::CordicStart);
	assign chain[0].y = '0;
	assign chain[0].r = $signed({{2{d[31]}}, d});
	assign q_pipe[0] = q;
	for (genvar i = 0; i < N; i++) begin : g_cell
		vsrt_cordic_cell #(.STEP(i)) u_cell (.clk(clk), .prev(chain[i]), .next_q(chain[i+1]));
		always_ff @(posedge clk) q_pipe[i+1] <= q_pipe[i];
	end
	assign xr = (chain[N].x + 34'sd8192) >>> 14;
	assign yr = (chain[N].y + 34'sd8192) >>> 14;
	assign xc = xr[17:0];
	assign yc = yr[17:0];
	always_ff @(posedge clk) begin
		unique case (q_pipe[N])
			2'd1: begin cos_q <= -yc; sin_q <= xc; end
			2'd2: begin cos_q <= -xc; sin_q <= -yc; end
			2'd3: begin cos_q <= yc; sin_q <= -xc; end
			default: begin cos_q <= xc; sin_q <= yc; end
		endcase
	end
endmodule
`default_nettype wire

// ===== design/vsrt_rotate_cell.sv =====
`default_nettype none
// Rotates the pair (a, b) by the given cosine and sine, two pipeline stages.
module vsrt_rotate_cell (
	input  wire logic clk,
	input  wire logic en,
	input  wire logic signed [45:0] a,
	input  wire logic signed [45:0] b,
	input  wire logic signed [17:0] c,
	input  wire logic signed [17:0] s,
	input  wire logic clip_in,
	output logic signed [45:0] a_s2,
	output logic signed [45:0] b_s2,
	output logic clip_s2
);
	localparam logic signed [65:0] Lim = 66'sd17592186044415;
	logic signed [65:0] ac_s1, bs_s1, as_s1, bc_s1, p, q, pr, qr;
	logic clip_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			ac_s1 <= 66'(a * c);
			bs_s1 <= 66'(b * s);
			as_s1 <= 66'(a * s);
			bc_s1 <= 66'(b * c);
			clip_s1 <= clip_in;
		end
	end
	assign p = (ac_s1 - bs_s1 + 66'sd32768) >>> 16;
	assign q = (as_s1 + bc_s1 + 66'sd32768) >>> 16;
	assign pr = (p > Lim) ? Lim : ((p < -Lim) ? -Lim : p);
	assign qr = (q > Lim) ? Lim : ((q < -Lim) ? -Lim : q);
	always_ff @(posedge clk) begin
		if (en) begin
			a_s2 <= pr[45:0];
			b_s2 <= qr[45:0];
			clip_s2 <= clip_s1 || (p != pr) || (q != qr);
		end
	end
endmodule
`default_nettype wire
